FILE: hdl/lfba_pkg.sv
// shared types, constants and helpers of the led fade and breath animator
package lfba_pkg;

    localparam int SEGMENTS = 4;
    localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int LEVEL_W  = 7;
    localparam int STEP_W   = 7;
    localparam int BSTEP_W  = 6;
    localparam int COLOUR_W = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_NONE   = 2'd0;
    localparam mode_t MODE_FADE   = 2'd1;
    localparam mode_t MODE_BREATH = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic [STEP_W-1:0]  step;
        mode_t              mode;
        logic               rising;
    } lfba_seg_t;

    typedef struct packed {
        logic [BSTEP_W-1:0] step;
        logic [LEVEL_W-1:0] low;
        logic [LEVEL_W-1:0] high;
    } lfba_breath_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        mode_t              mode;
        logic               rising;
        logic               dirty;
    } lfba_adv_t;

    function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

endpackage

FILE: hdl/lfba_ifs.sv
// valid/ready channel interfaces for input items and result words
interface lfba_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] segment;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] target_level;
    logic [1:0] mode;
    logic [6:0] fade_amount;

    modport source (
        output valid, kind, segment, red, green, blue, target_level, mode, fade_amount,
        input  ready
    );
    modport sink (
        input  valid, kind, segment, red, green, blue, target_level, mode, fade_amount,
        output ready
    );
endinterface

interface lfba_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_segment;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [6:0] level;
    logic       lit;
    logic       any_moving;
    logic       last;

    modport source (
        output valid, out_segment, out_red, out_green, out_blue, level, lit, any_moving, last,
        input  ready
    );
    modport sink (
        input  valid, out_segment, out_red, out_green, out_blue, level, lit, any_moving, last,
        output ready
    );
endinterface

FILE: hdl/led_fade_breath_animator_unit.sv
// top level of the led fade and breath animator
//
// usage: items arrive on in_item, result words leave on out_item, both
// valid/ready. a set item (kind 0) loads one segment with colour, target,
// mode and fade step (skipped if colour, target and mode already match);
// it gives no word. a tick item (kind 1) advances the four segments one per
// cycle through a single shared add and compare unit, then walks the
// segments in index order and sends one word for each dirty segment, last
// set on the final one.
// in_item.ready is high only while the sequencer is idle; a finished word may
// still wait in the output register while the next item is taken.
// when the receiver stalls, the emit walk holds on the next dirty segment.
// the breath registers sit on the apb port at 0x0, 0x4 and 0x8.
// reset: breath step 2, band 10 to 100, all segments dark, in none mode,
// and marked dirty so the first tick reports every segment.
module led_fade_breath_animator_unit import lfba_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lfba_in_if.sink     in_item,
    lfba_out_if.source  out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_BREATH_STEP = 2'd0;
    localparam logic [1:0] REG_BREATH_LOW  = 2'd1;
    localparam logic [1:0] REG_BREATH_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET,
        ST_ADV,
        ST_EMIT
    } state_t;

    logic [BSTEP_W-1:0] bstep_reg;
    logic [LEVEL_W-1:0] blow_reg;
    logic [LEVEL_W-1:0] bhigh_reg;

    state_t             state_reg;
    logic [SEG_W-1:0]   idx_reg;
    logic [1:0]         set_seg_reg;
    logic [COLOUR_W-1:0] set_colour_reg;
    logic [LEVEL_W-1:0] set_target_reg;
    mode_t              set_mode_reg;
    logic [STEP_W-1:0]  set_step_reg;

    logic [COLOUR_W-1:0] seg_colour_reg [SEGMENTS];
    logic [LEVEL_W-1:0]  seg_level_reg  [SEGMENTS];
    logic [LEVEL_W-1:0]  seg_target_reg [SEGMENTS];
    mode_t               seg_mode_reg   [SEGMENTS];
    logic [STEP_W-1:0]   seg_step_reg   [SEGMENTS];
    logic [SEGMENTS-1:0] seg_rising_reg;
    logic [SEGMENTS-1:0] seg_dirty_reg;

    logic                out_valid_reg;
    logic [1:0]          o_seg_reg;
    logic [COLOUR_W-1:0] o_colour_reg;
    logic [LEVEL_W-1:0]  o_level_reg;
    logic                o_lit_reg;
    logic                o_moving_reg;
    logic                o_last_reg;

    logic [LEVEL_W-1:0] lo_cap;
    logic [LEVEL_W-1:0] hi_cap;
    logic [SEG_W-1:0]   cur;
    logic               set_ok;
    logic               set_same;
    logic               moving;
    logic               more_after;
    logic               out_free;
    logic               emit_now;
    logic               cfg_wr;
    lfba_seg_t          cur_seg;
    lfba_breath_t       breath;
    lfba_adv_t          adv_res;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstep_reg <= 6'd2;
            blow_reg  <= 7'd10;
            bhigh_reg <= 7'd100;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BREATH_STEP: bstep_reg <= pwdata[BSTEP_W-1:0];
                REG_BREATH_LOW:  blow_reg  <= pwdata[LEVEL_W-1:0];
                REG_BREATH_HIGH: bhigh_reg <= pwdata[LEVEL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_BREATH_STEP: prdata = {{(32-BSTEP_W){1'b0}}, bstep_reg};
            REG_BREATH_LOW:  prdata = {{(32-LEVEL_W){1'b0}}, blow_reg};
            REG_BREATH_HIGH: prdata = {{(32-LEVEL_W){1'b0}}, bhigh_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // segment selection and shared unit
    assign lo_cap = cap_level(blow_reg);
    assign hi_cap = cap_level(bhigh_reg);
    assign cur    = (state_reg == ST_SET) ? SEG_W'(set_seg_reg) : idx_reg;
    assign set_ok = 32'(set_seg_reg) < 32'(SEGMENTS);

    assign set_same = (seg_colour_reg[cur] == set_colour_reg)
                   && (seg_target_reg[cur] == set_target_reg)
                   && (seg_mode_reg[cur] == set_mode_reg);

    assign cur_seg = '{level:  seg_level_reg[cur],
                       target: seg_target_reg[cur],
                       step:   seg_step_reg[cur],
                       mode:   seg_mode_reg[cur],
                       rising: seg_rising_reg[cur]};
    assign breath  = '{step: bstep_reg, low: lo_cap, high: hi_cap};

    lfba_adv u_adv (
        .seg    (cur_seg),
        .breath (breath),
        .res    (adv_res)
    );

    always_comb
    begin
        moving     = 1'b0;
        more_after = 1'b0;
        for (int j = 0; j < SEGMENTS; j++)
        begin
            if (seg_mode_reg[j] != MODE_NONE)
                moving = 1'b1;
            if (seg_dirty_reg[j] && (SEG_W'(j) > idx_reg))
                more_after = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || out_item.ready;
    assign emit_now = (state_reg == ST_EMIT) && seg_dirty_reg[cur] && out_free;

    // sequencer, segment state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            set_seg_reg    <= '0;
            set_colour_reg <= '0;
            set_target_reg <= '0;
            set_mode_reg   <= MODE_NONE;
            set_step_reg   <= '0;
            out_valid_reg  <= 1'b0;
            o_seg_reg      <= '0;
            o_colour_reg   <= '0;
            o_level_reg    <= '0;
            o_lit_reg      <= 1'b0;
            o_moving_reg   <= 1'b0;
            o_last_reg     <= 1'b0;
            seg_rising_reg <= '0;
            seg_dirty_reg  <= '1;
            for (int j = 0; j < SEGMENTS; j++)
            begin
                seg_colour_reg[j] <= '0;
                seg_level_reg[j]  <= '0;
                seg_target_reg[j] <= '0;
                seg_mode_reg[j]   <= MODE_NONE;
                seg_step_reg[j]   <= '0;
            end
        end
        else
        begin
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (out_item.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_item.valid)
                    begin
                        set_seg_reg    <= in_item.segment;
                        set_colour_reg <= {in_item.red, in_item.green, in_item.blue};
                        set_target_reg <= cap_level(in_item.target_level);
                        set_mode_reg   <= (in_item.mode inside {MODE_FADE, MODE_BREATH}) ?
                                          in_item.mode : MODE_NONE;
                        set_step_reg   <= in_item.fade_amount;
                        idx_reg        <= '0;
                        state_reg      <= in_item.kind ? ST_ADV : ST_SET;
                    end
                end
                ST_SET:
                begin
                    if (set_ok && !set_same)
                    begin
                        seg_colour_reg[cur] <= set_colour_reg;
                        seg_target_reg[cur] <= set_target_reg;
                        seg_mode_reg[cur]   <= set_mode_reg;
                        seg_step_reg[cur]   <= set_step_reg;
                        seg_dirty_reg[cur]  <= 1'b1;
                        if (set_mode_reg == MODE_BREATH)
                        begin
                            if (seg_level_reg[cur] > hi_cap)
                            begin
                                seg_level_reg[cur]  <= hi_cap;
                                seg_rising_reg[cur] <= 1'b0;
                            end
                            else if (seg_level_reg[cur] < lo_cap)
                            begin
                                seg_level_reg[cur]  <= lo_cap;
                                seg_rising_reg[cur] <= 1'b1;
                            end
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                ST_ADV:
                begin
                    seg_level_reg[cur]  <= adv_res.level;
                    seg_mode_reg[cur]   <= adv_res.mode;
                    seg_rising_reg[cur] <= adv_res.rising;
                    if (adv_res.dirty)
                        seg_dirty_reg[cur] <= 1'b1;
                    if (idx_reg == SEG_W'(SEGMENTS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (!seg_dirty_reg[cur] || out_free)
                    begin
                        if (seg_dirty_reg[cur])
                        begin
                            o_seg_reg          <= 2'(cur);
                            o_colour_reg       <= seg_colour_reg[cur];
                            o_level_reg        <= seg_level_reg[cur];
                            o_lit_reg          <= (seg_level_reg[cur] != '0);
                            o_moving_reg       <= moving;
                            o_last_reg         <= !more_after;
                            seg_dirty_reg[cur] <= 1'b0;
                        end
                        if (idx_reg == SEG_W'(SEGMENTS - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_item.ready        = (state_reg == ST_IDLE);
    assign out_item.valid       = out_valid_reg;
    assign out_item.out_segment = o_seg_reg;
    assign out_item.out_red     = o_colour_reg[23:16];
    assign out_item.out_green   = o_colour_reg[15:8];
    assign out_item.out_blue    = o_colour_reg[7:0];
    assign out_item.level       = o_level_reg;
    assign out_item.lit         = o_lit_reg;
    assign out_item.any_moving  = o_moving_reg;
    assign out_item.last        = o_last_reg;

`ifndef SYNTH
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> (out_item.level <= LEVEL_MAX))
        else $error("reported level above full scale");

    a_lit_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> (out_item.lit == (out_item.level != '0)))
        else $error("lit flag disagrees with level");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.ready && !out_item.last) |=>
        (!out_item.valid || (out_item.out_segment > $past(out_item.out_segment))))
        else $error("words of one tick out of segment order");
`endif

endmodule

FILE: hdl/lfba_adv.sv
// shared add and compare unit that advances one segment by one animation step
module lfba_adv import lfba_pkg::*; (
    input  lfba_seg_t    seg,
    input  lfba_breath_t breath,
    output lfba_adv_t    res
);

    logic signed [8:0] lv;
    logic signed [8:0] tg;
    logic signed [8:0] lo;
    logic signed [8:0] hi;
    logic signed [8:0] fstep;
    logic signed [8:0] diff;
    logic signed [8:0] mag;
    logic signed [8:0] addend;
    logic signed [8:0] sum;
    logic              sub;

    always_comb
    begin
        lv     = $signed({2'b00, seg.level});
        tg     = $signed({2'b00, seg.target});
        lo     = $signed({2'b00, breath.low});
        hi     = $signed({2'b00, breath.high});
        fstep  = $signed({2'b00, seg.step});
        diff   = tg - lv;
        mag    = diff[8] ? -diff : diff;
        sub    = (seg.mode == MODE_FADE) ? diff[8] : !seg.rising;
        addend = (seg.mode == MODE_FADE) ? fstep : $signed({3'b000, breath.step});
        sum    = sub ? (lv - addend) : (lv + addend);

        res.level  = seg.level;
        res.mode   = seg.mode;
        res.rising = seg.rising;
        res.dirty  = 1'b0;

        case (seg.mode)
            MODE_FADE:
            begin
                if (diff != 9'sd0)
                begin
                    res.dirty = 1'b1;
                    if (mag <= fstep)
                    begin
                        res.level = seg.target;
                        res.mode  = MODE_NONE;
                    end
                    else
                    begin
                        res.level = sum[LEVEL_W-1:0];
                    end
                end
                else
                begin
                    res.mode = MODE_NONE;
                end
            end
            MODE_BREATH:
            begin
                res.dirty = 1'b1;
                if (sum >= hi)
                begin
                    res.level  = breath.high;
                    res.rising = 1'b0;
                end
                else if (sum <= lo)
                begin
                    res.level  = breath.low;
                    res.rising = 1'b1;
                end
                else
                begin
                    res.level = sum[LEVEL_W-1:0];
                end
            end
            default:
            begin
                if (diff != 9'sd0)
                begin
                    res.level = seg.target;
                    res.dirty = 1'b1;
                end
            end
        endcase
    end

endmodule
